// ===== rtl/lrm_pkg.sv =====
// Shared types and constants for the line regex matcher.
package lrm_pkg;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 64;
  localparam int NUM_WORDS  = 4;
  localparam int LEN_W      = 6;

  localparam logic [CFG_IDX_W-1:0] REG_WORD_0 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_1 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_2 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_WORD_3 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_LENGTH = 3'd4;

  localparam logic [7:0] CH_STAR    = 8'h2A;
  localparam logic [7:0] CH_DOT     = 8'h2E;
  localparam logic [7:0] CH_DOLLAR  = 8'h24;
  localparam logic [7:0] CH_CARET   = 8'h5E;
  localparam logic [7:0] CH_NEWLINE = 8'h0A;
  localparam logic [7:0] CH_NUL     = 8'h00;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       end_of_input;
  } lrm_in_t;

  typedef struct packed {
    logic line_match;
    logic by_newline;
  } lrm_out_t;

  typedef struct packed {
    logic busy;
    logic anchored;
    logic dollar;
  } lrm_prog_flags_t;

endpackage

// ===== rtl/lrm_compiler.sv =====
// Pattern registers and the sequencer that turns the pattern into matcher elements.
module lrm_compiler import lrm_pkg::*; #(
  parameter int PATTERN_LEN = 32
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [CFG_IDX_W-1:0]                cfg_index,
  input  logic [CFG_DATA_W-1:0]               cfg_data,
  output logic [PATTERN_LEN-1:0][7:0]         elem_char,
  output logic [PATTERN_LEN-1:0]              elem_any,
  output logic [PATTERN_LEN-1:0]              elem_star,
  output logic [PATTERN_LEN-1:0]              elem_valid,
  output logic [$clog2(PATTERN_LEN+1)-1:0]    elem_count,
  output lrm_prog_flags_t                     flags
);

  localparam int CW = $clog2(PATTERN_LEN + 1);
  localparam int IW = (PATTERN_LEN > 1) ? $clog2(PATTERN_LEN) : 1;
  localparam int SW = 8 * PATTERN_LEN + 8;

  typedef enum logic [1:0] {ST_IDLE, ST_LOAD, ST_SCAN} state_t;

  state_t                 state;
  logic [CFG_DATA_W-1:0]  pattern_word [NUM_WORDS];
  logic [LEN_W-1:0]       pattern_length;
  logic [SW-1:0]          scan_sr;
  logic [CW-1:0]          scan_rem;
  logic                   scan_first;
  logic                   scan_skip;
  logic                   anchored;
  logic                   dollar;

  logic [NUM_WORDS*CFG_DATA_W-1:0] pattern_flat;
  logic [7:0]             cur;
  logic [7:0]             nxt;
  logic                   is_last;
  logic                   star_next;
  logic [IW-1:0]          cidx;
  logic [CW-1:0]          rem_init;

  assign pattern_flat = {pattern_word[3], pattern_word[2], pattern_word[1], pattern_word[0]};
  assign cur       = scan_sr[7:0];
  assign nxt       = scan_sr[15:8];
  // The current byte is the last one when the length runs out or a NUL follows.
  assign is_last   = (scan_rem == CW'(1)) || (nxt == CH_NUL);
  assign star_next = !is_last && (nxt == CH_STAR);
  assign cidx      = elem_count[IW-1:0];

  always_comb begin
    if (32'(pattern_length) > PATTERN_LEN) begin
      rem_init = CW'(PATTERN_LEN);
    end else begin
      rem_init = CW'(pattern_length);
    end
  end

  assign flags.busy     = (state != ST_IDLE);
  assign flags.anchored = anchored;
  assign flags.dollar   = dollar;

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_IDLE;
      pattern_word   <= '{default: '0};
      pattern_length <= '0;
      elem_valid     <= '0;
      elem_count     <= '0;
      anchored       <= 1'b0;
      dollar         <= 1'b0;
      scan_first     <= 1'b0;
      scan_skip      <= 1'b0;
      scan_rem       <= '0;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_WORD_0: pattern_word[0] <= cfg_data;
        REG_WORD_1: pattern_word[1] <= cfg_data;
        REG_WORD_2: pattern_word[2] <= cfg_data;
        REG_WORD_3: pattern_word[3] <= cfg_data;
        REG_LENGTH: pattern_length  <= cfg_data[LEN_W-1:0];
        default: ;
      endcase
      state <= ST_LOAD;
    end else begin
      unique case (state)
        ST_IDLE: ;
        ST_LOAD: begin
          scan_sr    <= {8'h00, pattern_flat[8*PATTERN_LEN-1:0]};
          scan_rem   <= rem_init;
          scan_first <= 1'b1;
          scan_skip  <= 1'b0;
          elem_count <= '0;
          elem_valid <= '0;
          anchored   <= 1'b0;
          dollar     <= 1'b0;
          state      <= ST_SCAN;
        end
        ST_SCAN: begin
          if (scan_rem == '0 || cur == CH_NUL) begin
            state <= ST_IDLE;
          end else begin
            scan_rem   <= scan_rem - CW'(1);
            scan_sr    <= scan_sr >> 8;
            scan_first <= 1'b0;
            if (scan_first && cur == CH_CARET) begin
              anchored <= 1'b1;
            end else if (scan_skip) begin
              // This byte is the star of the element just stored.
              scan_skip <= 1'b0;
            end else if (is_last && cur == CH_DOLLAR) begin
              dollar <= 1'b1;
              state  <= ST_IDLE;
            end else begin
              elem_char[cidx]  <= cur;
              elem_any[cidx]   <= (cur == CH_DOT);
              elem_star[cidx]  <= star_next;
              elem_valid[cidx] <= 1'b1;
              elem_count       <= elem_count + CW'(1);
              scan_skip        <= star_next;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/line_regex_matcher_core.sv =====
// Top level of the line regex matcher: per-byte position set update and line verdicts.
//
//  channel   signals                         direction  word
//  input     in_valid / in_ready / in_data   in         one text byte or end of input
//  output    out_valid / out_ready / out_data out       verdict for one finished line
//  config    cfg_we / cfg_index / cfg_data   in         one register write
//
// One input word is taken per cycle while no pattern load runs and the output
// register can take a verdict; the position set update and the verdict are
// combinational between the input handshake and the output register. After each
// register write the pattern sequencer walks the pattern one byte per cycle,
// holding in_ready low while it runs. Reset leaves an empty pattern ready at once.
// A stalled output holds in_ready low only while its register is full and not being taken.
module line_regex_matcher_core import lrm_pkg::*; #(
  parameter int PATTERN_LEN = 32
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  in_valid,
  output logic                  in_ready,
  input  lrm_in_t               in_data,
  output logic                  out_valid,
  input  logic                  out_ready,
  output lrm_out_t              out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int NP = PATTERN_LEN + 1;
  localparam int NL = $clog2(NP);
  localparam int CW = $clog2(PATTERN_LEN + 1);

  logic [PATTERN_LEN-1:0][7:0] elem_char;
  logic [PATTERN_LEN-1:0]      elem_any;
  logic [PATTERN_LEN-1:0]      elem_star;
  logic [PATTERN_LEN-1:0]      elem_valid;
  logic [CW-1:0]               elem_count;
  lrm_prog_flags_t             flags;

  logic [NP-1:0] active;
  logic          line_found;
  logic          line_frozen;
  logic          line_pending;

  logic [NL:0][NP-1:0] gen;
  logic [NL:0][NP-1:0] prop;
  logic [NP-1:0]       closed;
  logic [PATTERN_LEN-1:0] hit;
  logic [NP-1:0]       advanced;
  logic                accepting;
  logic                accept;
  logic                line_end;
  logic                emit;

  lrm_compiler #(.PATTERN_LEN(PATTERN_LEN)) u_compiler (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .elem_char  (elem_char),
    .elem_any   (elem_any),
    .elem_star  (elem_star),
    .elem_valid (elem_valid),
    .elem_count (elem_count),
    .flags      (flags)
  );

  // Closure over starred elements is a prefix OR along runs of stars, done as
  // a log-depth generate/propagate tree.
  always_comb begin
    gen[0]     = active | NP'(!flags.anchored);
    prop[0]    = '0;
    for (int j = 1; j < NP; j++) begin
      prop[0][j] = elem_star[j-1] & elem_valid[j-1];
    end
    for (int l = 0; l < NL; l++) begin
      for (int j = 0; j < NP; j++) begin
        if (j >= (1 << l)) begin
          gen[l+1][j]  = gen[l][j] | (prop[l][j] & gen[l][j-(1<<l)]);
          prop[l+1][j] = prop[l][j] & prop[l][j-(1<<l)];
        end else begin
          gen[l+1][j]  = gen[l][j];
          prop[l+1][j] = 1'b0;
        end
      end
    end
    closed = gen[NL];
  end

  assign accepting = closed[elem_count];

  always_comb begin
    for (int k = 0; k < PATTERN_LEN; k++) begin
      hit[k] = closed[k] & elem_valid[k]
             & (elem_any[k] | (elem_char[k] == in_data.text_byte));
    end
    for (int j = 0; j < NP; j++) begin
      advanced[j] = 1'b0;
      if (j < PATTERN_LEN) begin
        advanced[j] = advanced[j] | (hit[j] & elem_star[j]);
      end
      if (j > 0) begin
        advanced[j] = advanced[j] | (hit[j-1] & !elem_star[j-1]);
      end
    end
  end

  assign in_ready = !flags.busy && (!out_valid || out_ready);
  assign accept   = in_valid && in_ready;
  assign line_end = in_data.end_of_input || (in_data.text_byte == CH_NEWLINE);
  // An end of input with nothing in the line yields no word.
  assign emit     = accept && line_end && !(in_data.end_of_input && !line_pending);

  always_ff @(posedge clk) begin
    if (rst) begin
      active       <= NP'(1);
      line_found   <= 1'b0;
      line_frozen  <= 1'b0;
      line_pending <= 1'b0;
      out_valid    <= 1'b0;
    end else begin
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_valid && out_ready) begin
        out_valid <= 1'b0;
      end
      if (accept) begin
        if (line_end) begin
          if (emit) begin
            out_data.line_match <= line_found | (!line_frozen & accepting);
            out_data.by_newline <= !in_data.end_of_input;
          end
          active       <= NP'(1);
          line_found   <= 1'b0;
          line_frozen  <= 1'b0;
          line_pending <= 1'b0;
        end else begin
          line_pending <= 1'b1;
          if (!line_frozen) begin
            if (in_data.text_byte == CH_NUL) begin
              // A NUL ends the matched text; the rest of the line is ignored.
              if (accepting) begin
                line_found <= 1'b1;
              end
              line_frozen <= 1'b1;
            end else begin
              if (!flags.dollar && accepting) begin
                line_found <= 1'b1;
              end
              active <= advanced;
            end
          end
        end
      end
    end
  end

endmodule
